// ===== src/delta_patch_opcode_decoder_core_macros.svh =====
// Assertion macros used by the delta patch decoder checker
`ifndef DELTA_PATCH_OPCODE_DECODER_CORE_MACROS_SVH
`define DELTA_PATCH_OPCODE_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define DPOD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define DPOD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dpod_pkg.sv =====
// Shared constants, codes and types of the delta patch opcode decoder
package dpod_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned OP_W      = 2;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned PHASE_W   = 4;
   localparam int unsigned FAMILY_W  = 3;
   localparam int unsigned LEFT_W    = 3;
   localparam int unsigned POS_W     = 2;
   localparam int unsigned RSP_DATA_W = 80;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CSR_ADDR_W = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_COPY    = 2'd0;
   localparam logic [OP_W-1:0] OP_LITERAL = 2'd1;
   localparam logic [OP_W-1:0] OP_END     = 2'd2;
   localparam logic [OP_W-1:0] OP_ERROR   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_OPCODE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_LENGTH = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LEN_MISMATCH = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 3'd4;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_OPCODE  = 4'd0;
   localparam logic [PHASE_W-1:0] PH_LEN     = 4'd1;
   localparam logic [PHASE_W-1:0] PH_SHIFT8  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_SHIFT16 = 4'd3;
   localparam logic [PHASE_W-1:0] PH_SET     = 4'd4;
   localparam logic [PHASE_W-1:0] PH_WDATA   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_P_COPY  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_P_WLEN  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_P_WDATA = 4'd8;

   // opcode families
   localparam logic [FAMILY_W-1:0] FAM_NONE  = 3'd0;
   localparam logic [FAMILY_W-1:0] FAM_COPY  = 3'd1;
   localparam logic [FAMILY_W-1:0] FAM_WRITE = 3'd2;
   localparam logic [FAMILY_W-1:0] FAM_PATCH = 3'd3;
   localparam logic [FAMILY_W-1:0] FAM_ADDR  = 3'd4;

   // opcode high nibbles
   localparam logic [3:0] HI_SHIFT8  = 4'd8;
   localparam logic [3:0] HI_SHIFT16 = 4'd9;
   localparam logic [3:0] HI_SET     = 4'd10;
   localparam logic [3:0] HI_PATCH   = 4'd11;

   // length size codes in opcode bits 5:4
   localparam logic [1:0] SZ_NIBBLE = 2'd0;
   localparam logic [1:0] SZ_12     = 2'd1;
   localparam logic [1:0] SZ_20     = 2'd2;
   localparam logic [1:0] SZ_32     = 2'd3;

   // register index (paddr bit 2)
   localparam logic REG_PATCH_LENGTH    = 1'b0;
   localparam logic REG_EXPECTED_LENGTH = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] patch_length;
      logic [WORD_W-1:0] expected_output_length;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [WORD_W-1:0]   source_offset;
      logic [WORD_W-1:0]   copy_length;
      logic [BYTE_W-1:0]   literal_byte;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_item_type;

endpackage

// ===== src/dpod_front.sv =====
// Front end: takes patch bytes, decodes opcodes, tracks offsets and counts
module dpod_front
   import dpod_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   input  logic [BYTE_W-1:0]  req_byte,
   input  logic               q_space,
   output logic               req_ready,
   output logic               push,
   output rsp_item_type       push_item
);

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [FAMILY_W-1:0] family_ff, family_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [WORD_W-1:0]   src_ff, src_in;
   logic [WORD_W-1:0]   litrem_ff, litrem_in;
   logic [WORD_W-1:0]   seen_ff, seen_in;
   logic [WORD_W-1:0]   outcnt_ff, outcnt_in;
   logic                halted_ff, halted_in;

   logic                cmd_valid;
   logic [OP_W-1:0]     cmd_op;
   logic [WORD_W-1:0]   cmd_off, cmd_len;
   logic [BYTE_W-1:0]   cmd_lit;
   logic [STATUS_W-1:0] err;
   logic [WORD_W-1:0]   add_n;
   logic [WORD_W-1:0]   acc_new;
   logic [WORD_W-1:0]   len_val;
   logic                len_go;
   logic [WORD_W-1:0]   lit_dec;
   logic [WORD_W:0]     cnt_sum;
   logic [3:0]          hi, lo;

   logic                accept, take, pre_end, post_end, finishing;
   logic [PHASE_W-1:0]  chk_phase;
   logic [WORD_W-1:0]   chk_cnt;
   logic [STATUS_W-1:0] fin_status;

   assign req_ready = q_space;
   assign accept    = req_valid & q_space;
   assign pre_end   = (seen_ff >= cfg.patch_length);
   assign post_end  = ({1'b0, seen_ff} + {{WORD_W{1'b0}}, 1'b1}) >= {1'b0, cfg.patch_length};
   assign take      = accept & ~halted_ff & ~pre_end;
   assign hi        = req_byte[7:4];
   assign lo        = req_byte[3:0];

   // decode of one byte against the current phase
   always_comb begin
      phase_in  = phase_ff;
      family_in = family_ff;
      left_in   = left_ff;
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      src_in    = src_ff;
      litrem_in = litrem_ff;
      outcnt_in = outcnt_ff;
      cmd_valid = 1'b0;
      cmd_op    = OP_COPY;
      cmd_off   = '0;
      cmd_len   = '0;
      cmd_lit   = '0;
      err       = ST_OK;
      add_n     = '0;
      len_val   = '0;
      len_go    = 1'b0;
      cnt_sum   = '0;
      acc_new   = acc_ff | ({{(WORD_W-BYTE_W){1'b0}}, req_byte} << {pos_ff, 3'b000});
      lit_dec   = litrem_ff - {{(WORD_W-1){1'b0}}, 1'b1};

      case (phase_ff)
         PH_OPCODE: begin
            if (!hi[3]) begin
               family_in = hi[2] ? FAM_WRITE : FAM_COPY;
               pos_in    = '0;
               case (hi[1:0])
                  SZ_NIBBLE: begin
                     len_go  = 1'b1;
                     len_val = {{(WORD_W-4){1'b0}}, lo};
                  end
                  SZ_12: begin
                     phase_in = PH_LEN;
                     left_in  = 3'd1;
                     acc_in   = {{(WORD_W-12){1'b0}}, lo, 8'd0};
                  end
                  SZ_20: begin
                     phase_in = PH_LEN;
                     left_in  = 3'd2;
                     acc_in   = {{(WORD_W-20){1'b0}}, lo, 16'd0};
                  end
                  default: begin
                     phase_in = PH_LEN;
                     left_in  = 3'd4;
                     acc_in   = '0;
                  end
               endcase
            end else begin
               case (hi)
                  HI_SHIFT8: begin
                     family_in = FAM_ADDR;
                     phase_in  = PH_SHIFT8;
                     left_in   = 3'd1;
                     acc_in    = '0;
                     pos_in    = '0;
                  end
                  HI_SHIFT16: begin
                     family_in = FAM_ADDR;
                     phase_in  = PH_SHIFT16;
                     left_in   = 3'd2;
                     acc_in    = '0;
                     pos_in    = '0;
                  end
                  HI_SET: begin
                     family_in = FAM_ADDR;
                     phase_in  = PH_SET;
                     left_in   = 3'd4;
                     acc_in    = '0;
                     pos_in    = '0;
                  end
                  HI_PATCH: begin
                     family_in = FAM_PATCH;
                     phase_in  = PH_P_COPY;
                  end
                  default: err = ST_BAD_OPCODE;
               endcase
            end
         end
         PH_LEN, PH_SHIFT8, PH_SHIFT16, PH_SET: begin
            acc_in  = acc_new;
            pos_in  = pos_ff + 2'd1;
            left_in = left_ff - 3'd1;
            if (left_in == '0) begin
               phase_in = PH_OPCODE;
               case (phase_ff)
                  PH_LEN: begin
                     len_go  = 1'b1;
                     len_val = acc_new;
                  end
                  PH_SHIFT8:
                     src_in = src_ff + {{(WORD_W-8){acc_new[7]}}, acc_new[7:0]};
                  PH_SHIFT16:
                     src_in = src_ff + {{(WORD_W-16){acc_new[15]}}, acc_new[15:0]};
                  default:
                     src_in = acc_new;
               endcase
            end
         end
         PH_WDATA, PH_P_WDATA: begin
            cmd_valid = 1'b1;
            cmd_op    = OP_LITERAL;
            cmd_lit   = req_byte;
            add_n     = {{(WORD_W-1){1'b0}}, 1'b1};
            litrem_in = lit_dec;
            if (lit_dec == '0)
               phase_in = (phase_ff == PH_WDATA) ? PH_OPCODE : PH_P_COPY;
         end
         PH_P_COPY: begin
            if (req_byte == '0) begin
               phase_in = PH_OPCODE;
            end else begin
               if (req_byte[6:0] != '0) begin
                  cmd_valid = 1'b1;
                  cmd_op    = OP_COPY;
                  cmd_off   = src_ff;
                  cmd_len   = {{(WORD_W-7){1'b0}}, req_byte[6:0]};
                  add_n     = cmd_len;
               end
               if (req_byte[7]) begin
                  litrem_in = {{(WORD_W-1){1'b0}}, 1'b1};
                  phase_in  = PH_P_WDATA;
               end else begin
                  phase_in  = PH_P_WLEN;
               end
            end
         end
         PH_P_WLEN: begin
            if (req_byte == '0) begin
               phase_in = PH_OPCODE;
            end else begin
               litrem_in = {{(WORD_W-BYTE_W){1'b0}}, req_byte};
               phase_in  = PH_P_WDATA;
            end
         end
         default: phase_in = PH_OPCODE;
      endcase

      // a complete length field: zero is a fault, copies go out, writes open data
      if (len_go) begin
         if (len_val == '0) begin
            err = ST_ZERO_LENGTH;
         end else if (family_in == FAM_COPY) begin
            cmd_valid = 1'b1;
            cmd_op    = OP_COPY;
            cmd_off   = src_ff;
            cmd_len   = len_val;
            add_n     = len_val;
         end else begin
            litrem_in = len_val;
            phase_in  = PH_WDATA;
         end
      end

      // both copies and literals advance the source offset
      if (cmd_valid) begin
         src_in    = src_ff + add_n;
         cnt_sum   = {1'b0, outcnt_ff} + {1'b0, add_n};
         outcnt_in = cnt_sum[WORD_W] ? '1 : cnt_sum[WORD_W-1:0];
      end
   end

   // result selection
   always_comb begin
      chk_phase  = pre_end ? phase_ff : phase_in;
      chk_cnt    = pre_end ? outcnt_ff : outcnt_in;
      fin_status = ST_OK;
      if (chk_phase != PH_OPCODE)
         fin_status = ST_TRUNCATED;
      else if (chk_cnt != cfg.expected_output_length)
         fin_status = ST_LEN_MISMATCH;

      finishing = pre_end | ((err == ST_OK) & post_end);
      seen_in   = seen_ff + {{(WORD_W-1){1'b0}}, 1'b1};
      halted_in = halted_ff | (accept & ~halted_ff & (finishing | (err != ST_OK)));

      push      = 1'b0;
      push_item = '{operation: OP_END, source_offset: '0, copy_length: '0,
                    literal_byte: '0, status: ST_OK, last: 1'b1};
      if (accept && !halted_ff) begin
         if (!pre_end && err != ST_OK) begin
            push             = 1'b1;
            push_item.operation = OP_ERROR;
            push_item.status = err;
         end else if (finishing) begin
            push = 1'b1;
            if (fin_status != ST_OK) begin
               push_item.operation = OP_ERROR;
               push_item.status    = fin_status;
            end else if (!pre_end && cmd_valid) begin
               push_item.operation     = cmd_op;
               push_item.source_offset = cmd_off;
               push_item.copy_length   = cmd_len;
               push_item.literal_byte  = cmd_lit;
            end
         end else if (cmd_valid) begin
            push                    = 1'b1;
            push_item.operation     = cmd_op;
            push_item.source_offset = cmd_off;
            push_item.copy_length   = cmd_len;
            push_item.literal_byte  = cmd_lit;
            push_item.last          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         family_ff <= FAM_NONE;
         left_ff   <= '0;
         acc_ff    <= '0;
         pos_ff    <= '0;
         src_ff    <= '0;
         litrem_ff <= '0;
         seen_ff   <= '0;
         outcnt_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         halted_ff <= halted_in;
         if (take) begin
            phase_ff  <= phase_in;
            family_ff <= family_in;
            left_ff   <= left_in;
            acc_ff    <= acc_in;
            pos_ff    <= pos_in;
            src_ff    <= src_in;
            litrem_ff <= litrem_in;
            seen_ff   <= seen_in;
            outcnt_ff <= outcnt_in;
         end
      end
   end

endmodule

// ===== src/dpod_queue.sv =====
// Back end: short result queue whose head drives the response channel
module dpod_queue
   import dpod_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         space,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   rsp_item_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;

   assign space     = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/dpod_csr.sv =====
// Configuration registers behind the APB-style port
module dpod_csr
   import dpod_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [WORD_W-1:0]     csr_pwdata,
   output logic [WORD_W-1:0]     csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [WORD_W-1:0] plen_ff, plen_in;
   logic [WORD_W-1:0] olen_ff, olen_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      plen_in = plen_ff;
      olen_in = olen_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_PATCH_LENGTH:    plen_in = csr_pwdata;
            REG_EXPECTED_LENGTH: olen_in = csr_pwdata;
            default:             plen_in = plen_ff;
         endcase
      end
      case (csr_paddr[2])
         REG_PATCH_LENGTH:    csr_prdata = plen_ff;
         REG_EXPECTED_LENGTH: csr_prdata = olen_ff;
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.patch_length           = plen_ff;
   assign cfg.expected_output_length = olen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         olen_ff <= '0;
      end else begin
         plen_ff <= plen_in;
         olen_ff <= olen_in;
      end
   end

endmodule

// ===== src/delta_patch_opcode_decoder_core.sv =====
// Top level of the delta patch opcode decoder
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+----------------------------------------
//  req_     | in  | tvalid / tready    | one patch body byte per request
//  rsp_     | out | tvalid / tready    | copy, literal, end or error; tlast ends
//  csr_     | in  | psel/penable/pready| patch_length @0x0, expected length @0x4
//
// One byte is decoded per cycle; a request is taken every cycle while the
// result queue (two entries) has room, so a full-rate sink never stalls the parser.
// Each result is written into the result queue and reaches rsp_ from its head.
// Every byte updates offset and counters in one pass of the front parser;
// the 32-bit offset add and the output-count compare set the cycle.
// Synchronous reset clears parser state, counters, queue and registers.
// After a final or error result the block swallows bytes until reset.
module delta_patch_opcode_decoder_core
   import dpod_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // patch byte stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] patch_byte
   // decoded commands
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] source_offset, [63:32] copy_length,
                                               // [71:64] literal_byte, [74:72] status, zero pad
   output logic [OP_W-1:0]        rsp_tuser,   // [1:0] operation
   output logic                   rsp_tlast,   // last
   // configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [WORD_W-1:0]      csr_pwdata,
   output logic [WORD_W-1:0]      csr_prdata,
   output logic                   csr_pready
);

   cfg_type      cfg;
   logic         q_space;
   logic         push;
   rsp_item_type push_item;
   rsp_item_type head;

   dpod_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // parser: classifies each byte and pushes at most one result
   dpod_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_byte  (req_tdata),
      .q_space   (q_space),
      .req_ready (req_tready),
      .push      (push),
      .push_item (push_item)
   );

   // queue decouples the parser from a stalling sink
   dpod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (q_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 2*WORD_W - BYTE_W - STATUS_W){1'b0}},
                       head.status, head.literal_byte, head.copy_length,
                       head.source_offset};
   assign rsp_tuser = head.operation;
   assign rsp_tlast = head.last;

endmodule

// ===== src/dpod_checker.sv =====
// Port-level checks on the decoder, bound to the top level
`include "delta_patch_opcode_decoder_core_macros.svh"

module dpod_checker
   import dpod_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [OP_W-1:0]       rsp_tuser,
   input logic                  rsp_tlast
);

   // stalled result holds
   `DPOD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // errors always close the stream
   `DPOD_ASSERT_NOW(a_err_last, clock, reset, rsp_tvalid && rsp_tuser == OP_ERROR, rsp_tlast, "error result without last")

   // status is only nonzero on errors
   `DPOD_ASSERT_NOW(a_status_err, clock, reset, rsp_tvalid && rsp_tuser != OP_ERROR, rsp_tdata[74:72] == ST_OK, "status set on non-error result")

   // nothing follows the final result
   `DPOD_ASSERT_NEXT(a_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid, "result after final result")

endmodule

bind delta_patch_opcode_decoder_core dpod_checker u_dpod_checker (.*);
